@@ hw/rtl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// fixed-point widths, opcodes, status codes, pipeline payload and saturation
// ----------------------------------------------------------------------------
package cau_pkg;

  // operand format, signed q16.16
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FRAC_W  = 16;

  // derived widths
  localparam int unsigned PROD_W  = 2 * DATA_W;       // one exact product
  localparam int unsigned SUM_W   = PROD_W + 1;       // sum of two products
  localparam int unsigned ABS_W   = PROD_W;           // magnitude of such a sum
  localparam int unsigned DEN_W   = PROD_W;           // |b|^2
  localparam int unsigned QB      = DATA_W + 1;       // quotient bits kept
  localparam int unsigned SHIFT_W = QB - FRAC_W;      // pre-shift of the dividend
  localparam int unsigned STEPS   = QB;               // iteration stages
  localparam int unsigned SQ_N_W  = 2 * STEPS;        // radicand, zero padded
  localparam int unsigned ROOT_W  = STEPS;
  localparam int unsigned SQ_R_W  = ROOT_W + 3;
  localparam int unsigned WIDE_W  = PROD_W + 2;       // container for saturation
  localparam int unsigned SMP_W   = DATA_W + 1;       // add or subtract result

  localparam logic signed [WIDE_W-1:0] SAT_MAX =
    {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] SAT_MIN = ~SAT_MAX;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CONJ, OP_NEG, OP_MAG2, OP_MAG
  } cau_op_e;

  typedef enum logic [1:0] {
    ST_OK, ST_DZ, ST_SAT
  } cau_status_e;

  // payload carried through the divide and root stages
  typedef struct packed {
    cau_op_e                op;
    logic [DATA_W-1:0]      pre_re;
    logic [DATA_W-1:0]      pre_im;
    logic                   pre_sat;
    logic                   dz;
    logic                   neg_re;
    logic                   neg_im;
    logic                   ovf_re;
    logic                   ovf_im;
    logic [DEN_W-1:0]       den;
    logic [DEN_W-1:0]       rem_re;
    logic [DEN_W-1:0]       rem_im;
    logic [QB-1:0]          low_re;
    logic [QB-1:0]          low_im;
    logic [QB-1:0]          q_re;
    logic [QB-1:0]          q_im;
    logic [SQ_N_W-1:0]      sq_n;
    logic [SQ_R_W-1:0]      sq_rem;
    logic [ROOT_W-1:0]      sq_root;
  } cau_step_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              sat;
  } cau_sat_t;

  function automatic cau_sat_t sat_fn(input logic signed [WIDE_W-1:0] v);
    cau_sat_t r;
    if (v > SAT_MAX) begin
      r.val = SAT_MAX[DATA_W-1:0];
      r.sat = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val = SAT_MIN[DATA_W-1:0];
      r.sat = 1'b1;
    end else begin
      r.val = v[DATA_W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/cau_front.sv @@
// ----------------------------------------------------------------------------
// cau_front: products, sums, magnitudes and divider set-up
// four register stages ahead of the iteration chain
// ----------------------------------------------------------------------------
module cau_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  cau_pkg::cau_op_e                   op_i,
  input  logic signed [cau_pkg::DATA_W-1:0]  a_real_i,
  input  logic signed [cau_pkg::DATA_W-1:0]  a_imag_i,
  input  logic signed [cau_pkg::DATA_W-1:0]  b_real_i,
  input  logic signed [cau_pkg::DATA_W-1:0]  b_imag_i,
  output logic                               valid_o,
  output cau_pkg::cau_step_t                 step_o
);
  import cau_pkg::*;

  // stage 1: products and simple results
  logic v1_q, v2_q, v3_q, v4_q;
  cau_op_e op1_q, op2_q, op3_q;
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ir_q, p_ri_q;
  logic signed [PROD_W-1:0] m_ar_q, m_ai_q, m_br_q, m_bi_q;
  logic signed [SMP_W-1:0]  s_re_d, s_im_d, s_re1_q, s_im1_q, s_re2_q, s_im2_q;
  logic signed [SMP_W-1:0]  ar_w, ai_w, br_w, bi_w;

  assign ar_w = SMP_W'(a_real_i);
  assign ai_w = SMP_W'(a_imag_i);
  assign br_w = SMP_W'(b_real_i);
  assign bi_w = SMP_W'(b_imag_i);

  always_comb begin
    s_re_d = '0;
    s_im_d = '0;
    case (op_i)
      OP_ADD: begin
        s_re_d = ar_w + br_w;
        s_im_d = ai_w + bi_w;
      end
      OP_SUB: begin
        s_re_d = ar_w - br_w;
        s_im_d = ai_w - bi_w;
      end
      OP_CONJ: begin
        s_re_d = ar_w;
        s_im_d = -ai_w;
      end
      OP_NEG: begin
        s_re_d = -ar_w;
        s_im_d = -ai_w;
      end
      default: begin
        s_re_d = '0;
        s_im_d = '0;
      end
    endcase
  end

  // stage 2: sums of products
  logic signed [SUM_W-1:0] num_re_d, num_im_d, num_re_q, num_im_q;
  logic [DEN_W-1:0]        den2_q, mag2_2_q;

  always_comb begin
    if (op1_q == OP_DIV) begin
      num_re_d = SUM_W'(p_rr_q) + SUM_W'(p_ii_q);
      num_im_d = SUM_W'(p_ir_q) - SUM_W'(p_ri_q);
    end else begin
      num_re_d = SUM_W'(p_rr_q) - SUM_W'(p_ii_q);
      num_im_d = SUM_W'(p_ir_q) + SUM_W'(p_ri_q);
    end
  end

  // stage 3: magnitudes and non-divide results
  logic [ABS_W-1:0]  abs_re_q, abs_im_q;
  logic              neg_re_q, neg_im_q, dz_q;
  logic [DEN_W-1:0]  den3_q, mag2_3_q;
  cau_sat_t          sr_d, si_d;
  logic [DATA_W-1:0] pre_re_q, pre_im_q;
  logic              pre_sat_q;
  logic [SUM_W-1:0]  nabs_re, nabs_im;

  assign nabs_re = num_re_q[SUM_W-1] ? SUM_W'(-num_re_q) : SUM_W'(num_re_q);
  assign nabs_im = num_im_q[SUM_W-1] ? SUM_W'(-num_im_q) : SUM_W'(num_im_q);

  always_comb begin
    sr_d = '0;
    si_d = '0;
    case (op2_q)
      OP_ADD, OP_SUB, OP_CONJ, OP_NEG: begin
        sr_d = sat_fn(WIDE_W'(s_re2_q));
        si_d = sat_fn(WIDE_W'(s_im2_q));
      end
      OP_MUL: begin
        sr_d = sat_fn(WIDE_W'(num_re_q >>> FRAC_W));
        si_d = sat_fn(WIDE_W'(num_im_q >>> FRAC_W));
      end
      OP_MAG2: begin
        sr_d = sat_fn(signed'(WIDE_W'(mag2_2_q >> FRAC_W)));
      end
      default: begin
        sr_d = '0;
        si_d = '0;
      end
    endcase
  end

  // stage 4: divider set-up
  cau_step_t step_d, step_q;

  always_comb begin
    step_d         = '0;
    step_d.op      = op3_q;
    step_d.pre_re  = pre_re_q;
    step_d.pre_im  = pre_im_q;
    step_d.pre_sat = pre_sat_q;
    step_d.dz      = dz_q;
    step_d.neg_re  = neg_re_q;
    step_d.neg_im  = neg_im_q;
    step_d.den     = den3_q;
    // quotient needs more than QB bits
    step_d.ovf_re  = {{SHIFT_W{1'b0}}, abs_re_q} >= {den3_q, {SHIFT_W{1'b0}}};
    step_d.ovf_im  = {{SHIFT_W{1'b0}}, abs_im_q} >= {den3_q, {SHIFT_W{1'b0}}};
    step_d.rem_re  = DEN_W'(abs_re_q >> SHIFT_W);
    step_d.rem_im  = DEN_W'(abs_im_q >> SHIFT_W);
    step_d.low_re  = {abs_re_q[SHIFT_W-1:0], {FRAC_W{1'b0}}};
    step_d.low_im  = {abs_im_q[SHIFT_W-1:0], {FRAC_W{1'b0}}};
    step_d.sq_n    = SQ_N_W'(mag2_3_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q   <= op_i;
      p_rr_q  <= PROD_W'(a_real_i) * PROD_W'(b_real_i);
      p_ii_q  <= PROD_W'(a_imag_i) * PROD_W'(b_imag_i);
      p_ir_q  <= PROD_W'(a_imag_i) * PROD_W'(b_real_i);
      p_ri_q  <= PROD_W'(a_real_i) * PROD_W'(b_imag_i);
      m_ar_q  <= PROD_W'(a_real_i) * PROD_W'(a_real_i);
      m_ai_q  <= PROD_W'(a_imag_i) * PROD_W'(a_imag_i);
      m_br_q  <= PROD_W'(b_real_i) * PROD_W'(b_real_i);
      m_bi_q  <= PROD_W'(b_imag_i) * PROD_W'(b_imag_i);
      s_re1_q <= s_re_d;
      s_im1_q <= s_im_d;

      op2_q    <= op1_q;
      num_re_q <= num_re_d;
      num_im_q <= num_im_d;
      den2_q   <= DEN_W'(m_br_q) + DEN_W'(m_bi_q);
      mag2_2_q <= DEN_W'(m_ar_q) + DEN_W'(m_ai_q);
      s_re2_q  <= s_re1_q;
      s_im2_q  <= s_im1_q;

      op3_q     <= op2_q;
      abs_re_q  <= nabs_re[ABS_W-1:0];
      abs_im_q  <= nabs_im[ABS_W-1:0];
      neg_re_q  <= num_re_q[SUM_W-1];
      neg_im_q  <= num_im_q[SUM_W-1];
      dz_q      <= (op2_q == OP_DIV) && (den2_q == '0);
      den3_q    <= den2_q;
      mag2_3_q  <= mag2_2_q;
      pre_re_q  <= sr_d.val;
      pre_im_q  <= si_d.val;
      pre_sat_q <= sr_d.sat | si_d.sat;

      step_q <= step_d;
    end
  end

  assign valid_o = v4_q;
  assign step_o  = step_q;

endmodule

@@ hw/rtl/cau_step.sv @@
// ----------------------------------------------------------------------------
// cau_step: one restoring divide bit for both components and one root bit
// ----------------------------------------------------------------------------
module cau_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  cau_pkg::cau_step_t  step_i,
  output logic                valid_o,
  output cau_pkg::cau_step_t  step_o
);
  import cau_pkg::*;

  cau_step_t step_d, step_q;
  logic      valid_q;
  logic [DEN_W:0]    tr_re, tr_im, dd;
  logic [SQ_R_W-1:0] sr, st;
  logic              qb_re, qb_im;

  always_comb begin
    step_d = step_i;
    dd     = {1'b0, step_i.den};
    tr_re  = {step_i.rem_re, step_i.low_re[QB-1]};
    tr_im  = {step_i.rem_im, step_i.low_im[QB-1]};
    qb_re  = tr_re >= dd;
    qb_im  = tr_im >= dd;
    step_d.rem_re = qb_re ? DEN_W'(tr_re - dd) : DEN_W'(tr_re);
    step_d.rem_im = qb_im ? DEN_W'(tr_im - dd) : DEN_W'(tr_im);
    step_d.low_re = step_i.low_re << 1;
    step_d.low_im = step_i.low_im << 1;
    step_d.q_re   = {step_i.q_re[QB-2:0], qb_re};
    step_d.q_im   = {step_i.q_im[QB-2:0], qb_im};

    // digit-by-digit square root, two radicand bits per step
    sr = {step_i.sq_rem[SQ_R_W-3:0], step_i.sq_n[SQ_N_W-1 -: 2]};
    st = {1'b0, step_i.sq_root, 2'b01};
    step_d.sq_n = step_i.sq_n << 2;
    if (sr >= st) begin
      step_d.sq_rem  = sr - st;
      step_d.sq_root = {step_i.sq_root[ROOT_W-2:0], 1'b1};
    end else begin
      step_d.sq_rem  = sr;
      step_d.sq_root = {step_i.sq_root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign valid_o = valid_q;
  assign step_o  = step_q;

endmodule

@@ hw/rtl/cau_back.sv @@
// ----------------------------------------------------------------------------
// cau_back: quotient rounding, saturation, status and output register
// ----------------------------------------------------------------------------
module cau_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  cau_pkg::cau_step_t         step_i,
  output logic                       valid_o,
  output logic [cau_pkg::DATA_W-1:0] res_real_o,
  output logic [cau_pkg::DATA_W-1:0] res_imag_o,
  output cau_pkg::cau_status_e       status_o
);
  import cau_pkg::*;

  logic [QB:0]       mag_re, mag_im;
  logic [WIDE_W-1:0] w_re, w_im;
  cau_sat_t          d_re, d_im, root_s;
  logic [DATA_W-1:0] re_d, im_d, re_q, im_q;
  logic              sat_d;
  cau_status_e       st_d, st_q;
  logic              valid_q;

  always_comb begin
    // floor for negative quotients: bump magnitude when a remainder is left
    mag_re = step_i.ovf_re ? {1'b1, {QB{1'b0}}} :
             ({1'b0, step_i.q_re} + (QB+1)'(step_i.neg_re && (step_i.rem_re != '0)));
    mag_im = step_i.ovf_im ? {1'b1, {QB{1'b0}}} :
             ({1'b0, step_i.q_im} + (QB+1)'(step_i.neg_im && (step_i.rem_im != '0)));
    w_re   = step_i.neg_re ? (~WIDE_W'(mag_re) + 1'b1) : WIDE_W'(mag_re);
    w_im   = step_i.neg_im ? (~WIDE_W'(mag_im) + 1'b1) : WIDE_W'(mag_im);
    d_re   = sat_fn(signed'(w_re));
    d_im   = sat_fn(signed'(w_im));
    root_s = sat_fn(signed'(WIDE_W'(step_i.sq_root)));

    case (step_i.op)
      OP_DIV: begin
        re_d  = step_i.dz ? '0 : d_re.val;
        im_d  = step_i.dz ? '0 : d_im.val;
        sat_d = d_re.sat | d_im.sat;
      end
      OP_MAG: begin
        re_d  = root_s.val;
        im_d  = '0;
        sat_d = root_s.sat;
      end
      default: begin
        re_d  = step_i.pre_re;
        im_d  = step_i.pre_im;
        sat_d = step_i.pre_sat;
      end
    endcase

    if (step_i.dz) begin
      st_d = ST_DZ;
    end else if (sat_d) begin
      st_d = ST_SAT;
    end else begin
      st_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      re_q <= re_d;
      im_q <= im_d;
      st_q <= st_d;
    end
  end

  assign valid_o    = valid_q;
  assign res_real_o = re_q;
  assign res_imag_o = im_q;
  assign status_o   = st_q;

endmodule

@@ hw/rtl/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex alu on signed q16.16 operands
// add, subtract, multiply, divide, conjugate, negate, |a|^2 and |a|
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock unless the output is held and
// returns exactly one result transaction per input, in order, through four
// set-up stages, 33 iteration stages and the output register; throughput is
// one transaction per cycle unless stalled, set by the fully pipelined
// divider and square-root chain that performs one quotient bit and one root
// bit per stage. The whole pipeline advances together: when the output is
// held by m_axis_tready low, s_axis_tready drops and every stage holds.
// Multiply, divide and |a|^2 round toward minus infinity, |a| is the floor
// of the exact root, results outside the 32-bit range saturate with
// status 2, and division by 0+0i returns zero with status 1.
module complex_arithmetic_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // a_real, a_imag, b_real, b_imag
  input  logic [2:0]   s_axis_tuser,  // opcode
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // res_real, res_imag
  output logic [1:0]   m_axis_tuser   // status
);
  import cau_pkg::*;

  // one enable for the whole pipeline
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic      vld   [STEPS+1];
  cau_step_t stp   [STEPS+1];

  cau_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .op_i     (cau_op_e'(s_axis_tuser)),
    .a_real_i (s_axis_tdata[DATA_W-1:0]),
    .a_imag_i (s_axis_tdata[2*DATA_W-1:DATA_W]),
    .b_real_i (s_axis_tdata[3*DATA_W-1:2*DATA_W]),
    .b_imag_i (s_axis_tdata[4*DATA_W-1:3*DATA_W]),
    .valid_o  (vld[0]),
    .step_o   (stp[0])
  );

  // divider and root iteration chain
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    cau_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[i]),
      .step_i  (stp[i]),
      .valid_o (vld[i+1]),
      .step_o  (stp[i+1])
    );
  end

  cau_status_e status;
  logic [DATA_W-1:0] res_re, res_im;

  cau_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vld[STEPS]),
    .step_i     (stp[STEPS]),
    .valid_o    (m_axis_tvalid),
    .res_real_o (res_re),
    .res_imag_o (res_im),
    .status_o   (status)
  );

  assign m_axis_tdata = {res_im, res_re};
  assign m_axis_tuser = status;

  // divide by zero always returns a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == ST_DZ) |-> (res_re == '0) && (res_im == '0))
    else $error("divide by zero with nonzero result");

  // input is only refused while a result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused without output stall");

  // status code always meaningful
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (status == ST_OK) || (status == ST_DZ) || (status == ST_SAT))
    else $error("undefined status code");

  // a stalled pipeline keeps the valid that enters the iteration chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld[0]))
    else $error("pipeline moved during stall");

endmodule
